// File: src/ssl_pkg.sv
// Shared constants, types and helper functions for the sorted search list store.
package ssl_pkg;

	localparam int DEPTH = 16;
	localparam int DW    = 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int PW    = (CW > 5) ? CW : 5;

	typedef enum logic [3:0] {
		K_PUSH_F  = 4'd0,
		K_PUSH_B  = 4'd1,
		K_INSERT  = 4'd2,
		K_POP_F   = 4'd3,
		K_POP_B   = 4'd4,
		K_DELETE  = 4'd5,
		K_LSEARCH = 4'd6,
		K_SORT    = 4'd7,
		K_BSEARCH = 4'd8,
		K_REVERSE = 4'd9,
		K_LIST    = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_SH, S_INS_WR,
		S_DEL_CAP, S_DEL_SH, S_DEL_WR,
		S_LS_RD, S_LS_CMP,
		S_SO_OUT, S_SO_MIN, S_SO_RD, S_SO_CMP, S_SO_SWW, S_SO_SWI,
		S_BS_RD, S_BS_CMP,
		S_RV_CHK, S_RV_RDJ, S_RV_WRI, S_RV_WRJ,
		S_LI_RD, S_LI_OUT
	} state_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

	// sign-extend or truncate a 32-bit input to the stored width
	function automatic logic [DW-1:0] from_in(input logic [31:0] v);
		logic [DW-1:0] r;
		int src;
		for (int i = 0; i < DW; i++) begin
			src  = (i < 32) ? i : 31;
			r[i] = v[src];
		end
		return r;
	endfunction

	// sign-extend or truncate a stored word to the 32-bit output
	function automatic logic [31:0] to_out(input logic [DW-1:0] x);
		logic [31:0] r;
		int src;
		for (int i = 0; i < 32; i++) begin
			src  = (i < DW) ? i : DW - 1;
			r[i] = x[src];
		end
		return r;
	endfunction

endpackage

// File: src/sorted_search_list_store_top.sv
// Top level: command sequencer around the element store and the shared compare unit.
// A command is taken when start is high and busy is low; busy then stays high until
// its last result has been produced. Each result appears for one cycle with done high
// and cannot be held off. Every command gives one result except list, which gives one
// result per stored element with last marking the final one. Commands walk the store
// through the single read port: pushes and inserts move entries up to open a gap, pops
// and deletes move them down to close it, searches and list read elements in turn,
// reverse swaps pairs from the ends inward, and sort (also run before a binary search)
// is a selection sort. Errors are answered straight from idle, without raising busy.
module sorted_search_list_store_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  kind,
	input  logic [31:0] value,
	input  logic [4:0]  position,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] element,
	output logic [4:0]  found_position,
	output logic [4:0]  occupancy,
	output logic        last
);
	import ssl_pkg::*;

	state_t        state_q, state_d;
	kind_t         kind_q, kind_d;
	logic [DW-1:0] val_q, val_d, min_q, min_d, tmp_q, tmp_d;
	logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, idx_q, idx_d, lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0] m_q, m_d;

	logic          done_d, last_d;
	status_t       status_d;
	logic [31:0]   element_d;
	logic [4:0]    fpos_d;

	logic          done_q, last_q;
	status_t       status_q;
	logic [31:0]   element_q;
	logic [4:0]    fpos_q, occ_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata, cmp_b;
	cmp_res_t      cmp;

	logic [PW-1:0] pos_w, cnt_w;
	logic [CW:0]   i_inc, mid_sum;

	ssl_mem #(.Depth(DEPTH), .Width(DW), .AddrW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmp_b = (state_q == S_SO_CMP) ? min_q : val_q;

	ssl_cmp u_cmp (
		.a   (rdata),
		.b   (cmp_b),
		.res (cmp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		val_q  <= val_d;
		min_q  <= min_d;
		tmp_q  <= tmp_d;
		i_q    <= i_d;
		j_q    <= j_d;
		idx_q  <= idx_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		m_q    <= m_d;
		if (done_d) begin
			status_q  <= status_d;
			element_q <= element_d;
			fpos_q    <= fpos_d;
			last_q    <= last_d;
			occ_q     <= 5'(cnt_d);
		end
	end

	assign pos_w   = PW'(position);
	assign cnt_w   = PW'(cnt_q);
	assign i_inc   = {1'b0, i_q} + 1'b1;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

	// sequencer
	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		val_d     = val_q;
		min_d     = min_q;
		tmp_d     = tmp_q;
		cnt_d     = cnt_q;
		i_d       = i_q;
		j_d       = j_q;
		idx_d     = idx_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		m_d       = m_q;
		done_d    = 1'b0;
		status_d  = ST_OK;
		element_d = '0;
		fpos_d    = '0;
		last_d    = 1'b1;
		we        = 1'b0;
		waddr     = '0;
		wdata     = val_q;
		raddr     = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_d = kind_t'(kind);
					val_d  = from_in(value);
					i_d    = '0;
					priority case (kind_t'(kind))
						K_PUSH_F, K_PUSH_B, K_INSERT: begin
							if (cnt_q == CW'(DEPTH)) begin
								done_d   = 1'b1;
								status_d = ST_FULL;
							end else if (kind_t'(kind) == K_INSERT &&
									(pos_w == '0 || pos_w > cnt_w + 1'b1)) begin
								done_d   = 1'b1;
								status_d = ST_BADPOS;
							end else begin
								i_d     = cnt_q;
								state_d = S_INS_SH;
								if (kind_t'(kind) == K_PUSH_F) begin
									idx_d = '0;
								end else if (kind_t'(kind) == K_PUSH_B) begin
									idx_d = cnt_q;
								end else begin
									idx_d = CW'(pos_w - 1'b1);
								end
							end
						end
						K_POP_F, K_POP_B, K_DELETE: begin
							if (cnt_q == '0) begin
								done_d   = 1'b1;
								status_d = ST_EMPTY;
							end else if (kind_t'(kind) == K_DELETE &&
									(pos_w == '0 || pos_w > cnt_w)) begin
								done_d   = 1'b1;
								status_d = ST_BADPOS;
							end else begin
								if (kind_t'(kind) == K_POP_F) begin
									idx_d = '0;
								end else if (kind_t'(kind) == K_POP_B) begin
									idx_d = cnt_q - 1'b1;
								end else begin
									idx_d = CW'(pos_w - 1'b1);
								end
								raddr   = idx_d[AW-1:0];
								state_d = S_DEL_CAP;
							end
						end
						K_LSEARCH: state_d = S_LS_RD;
						K_SORT:    state_d = S_SO_OUT;
						K_BSEARCH: begin
							if (cnt_q == '0) begin
								done_d   = 1'b1;
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SO_OUT;
							end
						end
						K_REVERSE: begin
							if (cnt_q == '0) begin
								done_d = 1'b1;
							end else begin
								j_d     = cnt_q - 1'b1;
								state_d = S_RV_CHK;
							end
						end
						K_LIST: begin
							if (cnt_q == '0) begin
								done_d   = 1'b1;
								status_d = ST_EMPTY;
							end else begin
								state_d = S_LI_RD;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end

			// open a gap by moving entries up one place
			S_INS_SH: begin
				if (i_q == idx_q) begin
					we      = 1'b1;
					waddr   = idx_q[AW-1:0];
					wdata   = val_q;
					cnt_d   = cnt_q + 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					raddr   = AW'(i_q - 1'b1);
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				we      = 1'b1;
				waddr   = i_q[AW-1:0];
				wdata   = rdata;
				i_d     = i_q - 1'b1;
				state_d = S_INS_SH;
			end

			// keep the removed item, then close the gap
			S_DEL_CAP: begin
				tmp_d   = rdata;
				i_d     = idx_q;
				state_d = S_DEL_SH;
			end
			S_DEL_SH: begin
				if (i_inc >= {1'b0, cnt_q}) begin
					cnt_d     = cnt_q - 1'b1;
					done_d    = 1'b1;
					element_d = to_out(tmp_q);
					state_d   = S_IDLE;
				end else begin
					raddr   = AW'(i_inc);
					state_d = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				we      = 1'b1;
				waddr   = i_q[AW-1:0];
				wdata   = rdata;
				i_d     = CW'(i_inc);
				state_d = S_DEL_SH;
			end

			// linear search, first match wins
			S_LS_RD: begin
				if (i_q == cnt_q) begin
					done_d   = 1'b1;
					status_d = ST_NOTFOUND;
					state_d  = S_IDLE;
				end else begin
					raddr   = i_q[AW-1:0];
					state_d = S_LS_CMP;
				end
			end
			S_LS_CMP: begin
				if (cmp.eq) begin
					done_d  = 1'b1;
					fpos_d  = 5'(i_inc);
					state_d = S_IDLE;
				end else begin
					i_d     = CW'(i_inc);
					state_d = S_LS_RD;
				end
			end

			// selection sort: outer pass
			S_SO_OUT: begin
				if (i_inc >= {1'b0, cnt_q}) begin
					if (kind_q == K_BSEARCH) begin
						lo_d    = '0;
						hi_d    = cnt_q - 1'b1;
						state_d = S_BS_RD;
					end else begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					raddr   = i_q[AW-1:0];
					m_d     = i_q[AW-1:0];
					j_d     = CW'(i_inc);
					state_d = S_SO_MIN;
				end
			end
			S_SO_MIN: begin
				min_d   = rdata;
				state_d = S_SO_RD;
			end
			S_SO_RD: begin
				if (j_q == cnt_q) begin
					if (m_q != i_q[AW-1:0]) begin
						raddr   = i_q[AW-1:0];
						state_d = S_SO_SWW;
					end else begin
						i_d     = CW'(i_inc);
						state_d = S_SO_OUT;
					end
				end else begin
					raddr   = j_q[AW-1:0];
					state_d = S_SO_CMP;
				end
			end
			S_SO_CMP: begin
				if (cmp.lt) begin
					min_d = rdata;
					m_d   = j_q[AW-1:0];
				end
				j_d     = j_q + 1'b1;
				state_d = S_SO_RD;
			end
			// swap minimum into place
			S_SO_SWW: begin
				we      = 1'b1;
				waddr   = m_q;
				wdata   = rdata;
				state_d = S_SO_SWI;
			end
			S_SO_SWI: begin
				we      = 1'b1;
				waddr   = i_q[AW-1:0];
				wdata   = min_q;
				i_d     = CW'(i_inc);
				state_d = S_SO_OUT;
			end

			// binary search on the sorted store
			S_BS_RD: begin
				idx_d   = CW'(mid_sum >> 1);
				raddr   = AW'(mid_sum >> 1);
				state_d = S_BS_CMP;
			end
			S_BS_CMP: begin
				if (cmp.eq) begin
					done_d  = 1'b1;
					fpos_d  = 5'({1'b0, idx_q} + 1'b1);
					state_d = S_IDLE;
				end else if (cmp.lt) begin
					lo_d = idx_q + 1'b1;
					if (idx_q >= hi_q) begin
						done_d   = 1'b1;
						status_d = ST_NOTFOUND;
						state_d  = S_IDLE;
					end else begin
						state_d = S_BS_RD;
					end
				end else begin
					hi_d = idx_q - 1'b1;
					if (idx_q == lo_q) begin
						done_d   = 1'b1;
						status_d = ST_NOTFOUND;
						state_d  = S_IDLE;
					end else begin
						state_d = S_BS_RD;
					end
				end
			end

			// reverse by swapping ends inward
			S_RV_CHK: begin
				if (i_q >= j_q) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					raddr   = i_q[AW-1:0];
					state_d = S_RV_RDJ;
				end
			end
			S_RV_RDJ: begin
				raddr   = j_q[AW-1:0];
				tmp_d   = rdata;
				state_d = S_RV_WRI;
			end
			S_RV_WRI: begin
				we      = 1'b1;
				waddr   = i_q[AW-1:0];
				wdata   = rdata;
				state_d = S_RV_WRJ;
			end
			S_RV_WRJ: begin
				we      = 1'b1;
				waddr   = j_q[AW-1:0];
				wdata   = tmp_q;
				i_d     = CW'(i_inc);
				j_d     = j_q - 1'b1;
				state_d = S_RV_CHK;
			end

			// list every item in order
			S_LI_RD: begin
				raddr   = i_q[AW-1:0];
				state_d = S_LI_OUT;
			end
			S_LI_OUT: begin
				done_d    = 1'b1;
				element_d = to_out(rdata);
				last_d    = (i_inc == {1'b0, cnt_q});
				i_d       = CW'(i_inc);
				state_d   = last_d ? S_IDLE : S_LI_RD;
			end

			default: state_d = S_IDLE;
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign element        = element_q;
	assign found_position = fpos_q;
	assign occupancy      = occ_q;
	assign last           = last_q;

endmodule

// File: src/ssl_mem.sv
// Element store: one write port, one read port with registered read data.
module ssl_mem #(
	parameter int Depth = 16,
	parameter int Width = 32,
	parameter int AddrW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/ssl_cmp.sv
// Shared signed compare unit used by search and sort steps.
module ssl_cmp (
	input  logic [ssl_pkg::DW-1:0] a,
	input  logic [ssl_pkg::DW-1:0] b,
	output ssl_pkg::cmp_res_t      res
);
	import ssl_pkg::*;

	always_comb begin
		res.eq = (a == b);
		res.lt = ($signed(a) < $signed(b));
	end

endmodule

// File: src/ssl_checker.sv
// Port-level checks for the sorted search list store, bound to the top level.
module ssl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] element,
	input logic [4:0]  found_position,
	input logic [4:0]  occupancy,
	input logic        last
);
	import ssl_pkg::*;

	// an error always ends the command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> last)
		else $error("error result without last");

	// only list results continue, and they are all good
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> (status == ST_OK))
		else $error("non-final result with error status");

	// empty store reports no occupancy
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (occupancy == 5'd0))
		else $error("empty status with items held");

	// a hit lies inside the store, with good status and a zero element
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_position != 5'd0) |->
			(status == ST_OK && found_position <= occupancy && element == 32'd0))
		else $error("found position out of range");

	// a non-final item is followed by more of the same command
	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> busy)
		else $error("idle between list items");

endmodule

bind sorted_search_list_store_top ssl_checker u_ssl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.element        (element),
	.found_position (found_position),
	.occupancy      (occupancy),
	.last           (last)
);
